>>> rtl/sorted_key_index_table_defines.svh
// ----------------------------------------------------------------------------
// sorted_key_index_table_defines
// assertion macros shared by the sorted key index table rtl
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_INDEX_TABLE_DEFINES_SVH
`define SORTED_KEY_INDEX_TABLE_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define SKIT_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// antecedent implies consequent in the next cycle
`define SKIT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

// antecedent implies consequent in the same cycle
`define SKIT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/skit_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skit_pkg
// types, codes and defaults shared by the sorted key index table
// ----------------------------------------------------------------------------
package skit_pkg;

	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int KEY_W  = 32;
	localparam int REC_W  = 31;
	localparam int HELD_W = 11;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_UPDATE = 2'd2,
		REQ_UNUSED = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} stat_t;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_INS,
		OP_DEL_KEY,
		OP_DEL_REC
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PLACE,
		ST_DONE
	} state_t;

	// broadcast command to every cell
	typedef struct packed {
		op_t                     op;
		logic signed [KEY_W-1:0] key;
		logic [REC_W-1:0]        rec;
	} cmd_t;

	// contents of one cell as seen by its neighbors
	typedef struct packed {
		logic                    valid;
		logic signed [KEY_W-1:0] key;
		logic [REC_W-1:0]        rec;
	} ent_t;

endpackage

>>> rtl/skit_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skit_cell
// one table slot: compares against the broadcast command and shifts with its
// neighbors on insert and delete
// ----------------------------------------------------------------------------
module skit_cell import skit_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t cmd,
	input  ent_t prev_ent,
	input  logic prev_gt,
	input  logic prev_hit,
	input  ent_t next_ent,
	output ent_t ent,
	output logic gt,
	output logic hit
);

	logic                    valid_q;
	logic signed [KEY_W-1:0] key_q;
	logic [REC_W-1:0]        rec_q;
	logic                    match;
	logic                    take_prev;
	logic                    take_cmd;
	logic                    take_next;

	// local compares
	assign gt = valid_q && (key_q > cmd.key);
	always_comb begin
		case (cmd.op)
			OP_DEL_KEY: match = valid_q && (key_q == cmd.key);
			OP_DEL_REC: match = valid_q && (rec_q == cmd.rec);
			default:    match = 1'b0;
		endcase
	end
	assign hit = prev_hit || match;

	// move selection
	assign take_prev = (cmd.op == OP_INS) && prev_gt;
	assign take_cmd  = (cmd.op == OP_INS) && !prev_gt && (!valid_q || gt) && prev_ent.valid;
	assign take_next = ((cmd.op == OP_DEL_KEY) || (cmd.op == OP_DEL_REC)) && hit;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_prev || take_cmd) begin
			valid_q <= 1'b1;
		end else if (take_next) begin
			valid_q <= next_ent.valid;
		end
	end

	// slot payload
	always_ff @(posedge clk) begin
		if (take_prev) begin
			key_q <= prev_ent.key;
			rec_q <= prev_ent.rec;
		end else if (take_cmd) begin
			key_q <= cmd.key;
			rec_q <= cmd.rec;
		end else if (take_next) begin
			key_q <= next_ent.key;
			rec_q <= next_ent.rec;
		end
	end

	assign ent = '{valid: valid_q, key: key_q, rec: rec_q};

endmodule

>>> rtl/sorted_key_index_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_index_table
// sorted (key, record) table built as a chain of slots with insert, remove by
// key and update of a record's key
// ----------------------------------------------------------------------------
// channel   signals                                     transfer when
// request   start busy req_type station_key record_number   start && !busy
// result    done status entries_held                    done (one cycle)
//
// insert, remove and an update whose record is absent go from start through the
// exec state to done; an update that finds its record also passes the place state
// (a delete pass over the chain, then a place pass). one slot pass per cycle.
// a new request is taken in the cycle done is shown.
// arst_n clears every slot's valid bit and the entry count; no clearing pass.
// the receiver cannot stall: done is a single-cycle strobe.
module sorted_key_index_table import skit_pkg::*; #(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              req_type,
	input  logic signed [KEY_W-1:0] station_key,
	input  logic [REC_W-1:0]        record_number,
	output logic                    done,
	output logic [1:0]              status,
	output logic [HELD_W-1:0]       entries_held
);

	`include "sorted_key_index_table_defines.svh"

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	state_t           state_q, state_d;
	req_t             req_q;
	logic signed [KEY_W-1:0] key_q;
	logic [REC_W-1:0] rec_q;
	stat_t            status_q;
	logic [CNT_W-1:0] count_q;
	cmd_t             cmd;
	logic             accept;
	logic             full;
	logic             found;

	ent_t ent  [TABLE_DEPTH];
	logic gt   [TABLE_DEPTH];
	logic hit  [TABLE_DEPTH];

	assign accept = start && !busy;
	assign busy   = (state_q == ST_EXEC) || (state_q == ST_PLACE);
	assign done   = (state_q == ST_DONE);
	assign full   = ent[TABLE_DEPTH-1].valid;
	assign found  = hit[TABLE_DEPTH-1];

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_t'(req_type);
			key_q <= station_key;
			rec_q <= record_number;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (accept) state_d = ST_EXEC;
			ST_EXEC:  state_d = (req_q == REQ_UPDATE && found) ? ST_PLACE : ST_DONE;
			ST_PLACE: state_d = ST_DONE;
			ST_DONE:  state_d = accept ? ST_EXEC : ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// command broadcast to the chain
	always_comb begin
		cmd.op  = OP_NOP;
		cmd.key = key_q;
		cmd.rec = rec_q;
		case (state_q)
			ST_EXEC: begin
				case (req_q)
					REQ_INSERT: cmd.op = full ? OP_NOP : OP_INS;
					REQ_REMOVE: cmd.op = OP_DEL_KEY;
					REQ_UPDATE: cmd.op = OP_DEL_REC;
					default:    cmd.op = OP_NOP;
				endcase
			end
			ST_PLACE: cmd.op = OP_INS;
			default:  cmd.op = OP_NOP;
		endcase
	end

	// status of the request
	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			case (req_q)
				REQ_INSERT: status_q <= full ? STAT_FULL : STAT_OK;
				REQ_REMOVE: status_q <= found ? STAT_OK : STAT_NOT_FOUND;
				REQ_UPDATE: status_q <= found ? STAT_OK : STAT_NOT_FOUND;
				default:    status_q <= STAT_NOT_FOUND;
			endcase
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.op == OP_INS) begin
			count_q <= count_q + CNT_W'(1);
		end else if ((cmd.op == OP_DEL_KEY || cmd.op == OP_DEL_REC) && found) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign status       = status_q;
	assign entries_held = HELD_W'(count_q);

	// chain of slots
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		ent_t p_ent, n_ent;
		logic p_gt, p_hit;
		if (i == 0) begin : g_first
			assign p_ent = '{valid: 1'b1, key: '0, rec: '0};
			assign p_gt  = 1'b0;
			assign p_hit = 1'b0;
		end else begin : g_mid
			assign p_ent = ent[i-1];
			assign p_gt  = gt[i-1];
			assign p_hit = hit[i-1];
		end
		if (i == TABLE_DEPTH - 1) begin : g_last
			assign n_ent = '{valid: 1'b0, key: '0, rec: '0};
		end else begin : g_next
			assign n_ent = ent[i+1];
		end
		skit_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.prev_ent (p_ent),
			.prev_gt  (p_gt),
			.prev_hit (p_hit),
			.next_ent (n_ent),
			.ent      (ent[i]),
			.gt       (gt[i]),
			.hit      (hit[i])
		);
	end

	// checks
	`SKIT_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(TABLE_DEPTH), "entry count over depth")
	`SKIT_ASSERT_NEXT(a_accept_exec, accept, state_q == ST_EXEC, "accepted request not executed")
	`SKIT_ASSERT_SAME(a_full_status, done && status_q == STAT_FULL,
		count_q == CNT_W'(TABLE_DEPTH), "full reported with free slots")
	`SKIT_ASSERT_SAME(a_full_valid, full, count_q == CNT_W'(TABLE_DEPTH),
		"last slot valid but count short")

endmodule
